// ===== design/ssed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssed_pkg
// Shared constants, register indexes and types of the scale-space extremum
// detector.
// ----------------------------------------------------------------------------
package ssed_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // rows per frame are capped here regardless of the column parameter
  localparam int ROW_LIMIT = 1024;
  localparam int MIN_SIZE  = 3;

  localparam int COORD_W     = 10;
  localparam int SIZE_W      = 11;
  localparam int MARGIN_W    = 15;
  localparam int BORDER_W    = 9;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTREMUM_MARGIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BORDER_WIDTH    = 2'd3;

  localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 11'd480;
  // 0.01 in Q2.13, rounded
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 15'd82;
  localparam logic [BORDER_W-1:0] BORDER_RESET = 9'd16;

  // 3x3x3 window
  localparam int NUM_SCALES = 3;
  localparam int WIN_DIM    = 3;
  localparam int PLANE_TAPS = 9;
  localparam int CENTER_TAP = 4;

  typedef struct packed {
    logic lo_all;  // center + margin below every tap
    logic hi_all;  // center - margin above every tap
  } lane_flags_t;

endpackage

// ===== design/ssed_lstore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssed_lstore
// Line store: one entry per column holding the two previous rows. Registered
// read; a write to the address read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module ssed_lstore #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 96,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);
  import ssed_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] byp_q;
  logic              byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_q : rd_q;

endmodule

// ===== design/ssed_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssed_lane
// One scale plane of the window: compares the nine taps (eight on the middle
// scale) against the center bounds and registers the two all-taps flags.
// ----------------------------------------------------------------------------
module ssed_lane #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 17,
  parameter bit SKIP_CENTER = 1'b0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] plane [ssed_pkg::PLANE_TAPS],
  input  logic signed [SUM_W-1:0]       lo_bound,
  input  logic signed [SUM_W-1:0]       hi_bound,
  output ssed_pkg::lane_flags_t         flags
);
  import ssed_pkg::*;

  logic signed [SUM_W-1:0] ext [PLANE_TAPS];
  logic                    lo;
  logic                    hi;

  for (genvar i = 0; i < PLANE_TAPS; i++) begin : g_ext
    assign ext[i] = SUM_W'(plane[i]);
  end

  always_comb begin
    lo = 1'b1;
    hi = 1'b1;
    for (int i = 0; i < PLANE_TAPS; i++) begin
      if (!(SKIP_CENTER && (i == CENTER_TAP))) begin
        if (!(lo_bound < ext[i])) lo = 1'b0;
        if (!(hi_bound > ext[i])) hi = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.lo_all <= lo;
      flags.hi_all <= hi;
    end
  end

endmodule

// ===== design/scale_space_extremum_detector.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while out_ready is high; every stage has its
// own valid and moves on its own, so bubbles close up and input is taken
// while a result waits.
// The line store does one read and one write per cycle, which sets that rate.
// Reset (rst, synchronous): registers to their defaults, position to (0,0),
// pipeline emptied. Line store contents are undefined until written.
// ----------------------------------------------------------------------------
// scale_space_extremum_detector
// 3x3x3 difference-of-Gaussian extremum test on a raster stream of three
// scale images, with one two-row line store and a sliding window.
// ----------------------------------------------------------------------------
module scale_space_extremum_detector #(
  parameter int MAX_WIDTH   = ssed_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = ssed_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [ssed_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssed_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_below,
  input  logic signed [SAMPLE_BITS-1:0]       sample_middle,
  input  logic signed [SAMPLE_BITS-1:0]       sample_above,
  input  logic                                frame_start,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssed_pkg::COORD_W-1:0]        center_x,
  output logic [ssed_pkg::COORD_W-1:0]        center_y,
  output logic                                in_region,
  output logic                                is_minimum,
  output logic                                is_maximum
);
  import ssed_pkg::*;

  // column counter indexes the line store
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = COL_W + 1;
  localparam int WW     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int XS_W   = WW + 1;
  localparam int YS_W   = SIZE_W + 1;
  // compare width: holds center +/- margin without overflow
  localparam int SUM_W  = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W + 1) + 1;
  localparam int PIX_W  = NUM_SCALES * SAMPLE_BITS;
  localparam int LS_W   = 2 * PIX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  logic [MARGIN_W-1:0] extremum_margin;
  logic [BORDER_W-1:0] border_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
      extremum_margin <= MARGIN_RESET;
      border_width    <= BORDER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[SIZE_W-1:0];
        REG_EXTREMUM_MARGIN: extremum_margin <= cfg_data[MARGIN_W-1:0];
        REG_BORDER_WIDTH:    border_width    <= cfg_data[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [3, MAX_WIDTH], height to [3, 1024]
  logic [WW-1:0]     w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_comb begin
    w_eff = WW'(image_width);
    if (w_eff < WW'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = image_height;
    if (h_eff < SIZE_W'(MIN_SIZE)) begin
      h_eff = SIZE_W'(MIN_SIZE);
    end else if (h_eff > SIZE_W'(ROW_LIMIT)) begin
      h_eff = SIZE_W'(ROW_LIMIT);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: each stage loads when empty or when it empties this cycle
  // --------------------------------------------------------------------------
  logic v1, v2, v3;
  logic ready_o, ready3, ready2, ready1;
  logic in_acc, mv12, mv23, mv3o;

  assign ready_o  = !out_valid || out_ready;
  assign ready3   = !v3 || ready_o;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  assign in_acc = in_valid && ready1;
  assign mv12   = v1 && ready2;
  assign mv23   = v2 && ready3;
  assign mv3o   = v3 && ready_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1)  v1        <= in_valid;
      if (ready2)  v2        <= v1;
      if (ready3)  v3        <= v2;
      if (ready_o) out_valid <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // Raster position of the incoming pixel. A shrunken size or a frame end
  // wraps the counters; frame_start forces (0,0).
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   column_count, column_count_next;
  logic [COORD_W-1:0] row_count, row_count_next;
  logic [CNT_W-1:0]   pre_col, nxt_col;
  logic [SIZE_W-1:0]  pre_row, nxt_row;
  logic [COL_W-1:0]   col;
  logic [COORD_W-1:0] row;

  always_comb begin
    pre_col = frame_start ? '0 : CNT_W'(column_count);
    pre_row = frame_start ? '0 : SIZE_W'(row_count);
    if (WW'(pre_col) >= w_eff) begin
      pre_col = '0;
      pre_row = pre_row + SIZE_W'(1);
    end
    if (pre_row >= h_eff) begin
      pre_row = '0;
    end
    col = pre_col[COL_W-1:0];
    row = pre_row[COORD_W-1:0];

    nxt_col = CNT_W'(col) + CNT_W'(1);
    nxt_row = SIZE_W'(row);
    if (WW'(nxt_col) >= w_eff) begin
      nxt_col = '0;
      nxt_row = SIZE_W'(row) + SIZE_W'(1);
      if (nxt_row >= h_eff) begin
        nxt_row = '0;
      end
    end
    column_count_next = nxt_col[COL_W-1:0];
    row_count_next    = nxt_row[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store read in flight, position and samples held
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]              s1_col;
  logic [COORD_W-1:0]            s1_row;
  logic signed [SAMPLE_BITS-1:0] s1_smp [NUM_SCALES];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col    <= col;
      s1_row    <= row;
      s1_smp[0] <= sample_below;
      s1_smp[1] <= sample_middle;
      s1_smp[2] <= sample_above;
    end
  end

  // entry layout: [PIX_W-1:0] previous row, [LS_W-1:PIX_W] row before it;
  // scale k sits at bits k*SAMPLE_BITS of each half
  logic [LS_W-1:0] ls_rd;
  logic [LS_W-1:0] ls_wr;

  assign ls_wr = {ls_rd[PIX_W-1:0], s1_smp[2], s1_smp[1], s1_smp[0]};

  ssed_lstore #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LS_W)
  ) u_lstore (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (ls_rd),
    .wr_en   (mv12),
    .wr_addr (s1_col),
    .wr_data (ls_wr)
  );

  // Window center is one row and one column behind; region check here
  logic               s1_complete;
  logic [COL_W-1:0]   s1_cx;
  logic [COORD_W-1:0] s1_cy;
  logic               s1_region;

  always_comb begin
    s1_complete = (s1_col >= COL_W'(2)) && (s1_row >= COORD_W'(2));
    s1_cx       = s1_col - COL_W'(1);
    s1_cy       = s1_row - COORD_W'(1);
    s1_region   = s1_complete
                  && (WW'(s1_cx) >= WW'(border_width))
                  && ((XS_W'(s1_cx) + XS_W'(border_width)) < XS_W'(w_eff))
                  && (SIZE_W'(s1_cy) >= SIZE_W'(border_width))
                  && ((YS_W'(s1_cy) + YS_W'(border_width)) < YS_W'(h_eff));
  end

  // --------------------------------------------------------------------------
  // Stage 2: 3x3x3 window, win[column][row][scale]; column 0 oldest,
  // row 2 newest. Shifts once per word leaving stage 1.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] win [WIN_DIM][WIN_DIM][NUM_SCALES];
  logic [COORD_W-1:0]            s2_cx, s2_cy;
  logic                          s2_region;

  always_ff @(posedge clk) begin
    if (mv12) begin
      win[0] <= win[1];
      win[1] <= win[2];
      for (int k = 0; k < NUM_SCALES; k++) begin
        win[2][0][k] <= ls_rd[PIX_W + k*SAMPLE_BITS +: SAMPLE_BITS];
        win[2][1][k] <= ls_rd[k*SAMPLE_BITS +: SAMPLE_BITS];
        win[2][2][k] <= s1_smp[k];
      end
      s2_cx     <= s1_complete ? COORD_W'(s1_cx) : '0;
      s2_cy     <= s1_complete ? s1_cy : '0;
      s2_region <= s1_region;
    end
  end

  // center bounds, shared by all lanes
  logic signed [SUM_W-1:0] ctr_s, margin_s, lo_bound, hi_bound;

  assign ctr_s    = SUM_W'(win[1][1][1]);
  assign margin_s = signed'(SUM_W'(extremum_margin));
  assign lo_bound = ctr_s + margin_s;
  assign hi_bound = ctr_s - margin_s;

  // one lane per scale plane; middle lane skips the center tap
  logic signed [SAMPLE_BITS-1:0] plane [NUM_SCALES][PLANE_TAPS];
  lane_flags_t                   lane_flags [NUM_SCALES];

  always_comb begin
    for (int k = 0; k < NUM_SCALES; k++) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        for (int c = 0; c < WIN_DIM; c++) begin
          plane[k][r*WIN_DIM + c] = win[c][r][k];
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_SCALES; k++) begin : g_lane
    ssed_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .SKIP_CENTER (k == 1)
    ) u_lane (
      .clk      (clk),
      .en       (mv23),
      .plane    (plane[k]),
      .lo_bound (lo_bound),
      .hi_bound (hi_bound),
      .flags    (lane_flags[k])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: lane flags registered; merge into the output word
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] s3_cx, s3_cy;
  logic               s3_region;
  logic               all_lo, all_hi;

  always_ff @(posedge clk) begin
    if (mv23) begin
      s3_cx     <= s2_cx;
      s3_cy     <= s2_cy;
      s3_region <= s2_region;
    end
  end

  assign all_lo = lane_flags[0].lo_all && lane_flags[1].lo_all && lane_flags[2].lo_all;
  assign all_hi = lane_flags[0].hi_all && lane_flags[1].hi_all && lane_flags[2].hi_all;

  // minimum wins over maximum
  always_ff @(posedge clk) begin
    if (mv3o) begin
      center_x   <= s3_cx;
      center_y   <= s3_cy;
      in_region  <= s3_region;
      is_minimum <= s3_region && all_lo;
      is_maximum <= s3_region && !all_lo && all_hi;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_minimum && is_maximum))
    else $error("minimum and maximum flagged together");

  a_flags_need_region: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_minimum || is_maximum) |-> in_region)
    else $error("extremum flagged outside region");

  a_region_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_region |-> (center_x != '0) && (center_y != '0))
    else $error("region word with center on the frame edge");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && in_ready && frame_start |=> column_count == COL_W'(1))
    else $error("column counter not restarted by frame_start");

endmodule
